>>> rtl/height_map_to_normal_map_macros.svh
// Assertion macros shared by the height map to normal map RTL.
`ifndef HEIGHT_MAP_TO_NORMAL_MAP_MACROS_SVH
`define HEIGHT_MAP_TO_NORMAL_MAP_MACROS_SVH

// Same-cycle implication, clocked on clk_i, off while rst_ni is low.
`define HMN_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, clocked on clk_i, off while rst_ni is low.
`define HMN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/hmn_pkg.sv
// Types, constants and helper functions of the height map to normal map block.
package hmn_pkg;

  // Field widths
  localparam int CFG_W    = 11;
  localparam int HEIGHT_W = 8;
  localparam int PIX_W    = 10;
  localparam int COLOR_W  = 8;
  localparam int Q_W      = 16;

  // Default image limits
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // Configuration register indexes
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_WIDTH  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_HEIGHT = 1'b1;

  // Normalizer datapath widths
  localparam int VEC_W      = 21;  // signed operand, magnitude below 2^20
  localparam int MAG_W      = 20;
  localparam int SQ_W       = 2 * MAG_W;
  localparam int ACC_W      = SQ_W + 2;
  localparam int RAD_SHIFT  = 16;
  localparam int RAD_W      = ACC_W + RAD_SHIFT;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 3;
  localparam int SQRT_STEPS = ROOT_W;
  localparam int DIV_SHIFT  = 8;   // 2^23 / 2^15
  localparam int DIV_STEPS  = 15;
  localparam int DREM_W     = ROOT_W + 1;
  localparam int CNT_W      = 5;

  // Vertex z before normalization: 2550 - 4|S| - |T|
  localparam int Z_BASE = 2550;

  localparam logic signed [Q_W-1:0] Q_ONE = 16'sd32767;

  typedef struct packed {
    logic signed [Q_W-1:0] x;
    logic signed [Q_W-1:0] y;
    logic signed [Q_W-1:0] z;
  } nvec_t;

  localparam nvec_t BORDER_N = '{x: '0, y: '0, z: Q_ONE};

  typedef struct packed {
    logic                    start;
    logic signed [VEC_W-1:0] x;
    logic signed [VEC_W-1:0] y;
    logic signed [VEC_W-1:0] z;
  } norm_req_t;

  typedef struct packed {
    logic  done;
    nvec_t n;
  } norm_rsp_t;

  // floor(255 * (32768 + n) / 65536)
  function automatic logic [COLOR_W-1:0] ofs_byte(logic signed [Q_W-1:0] n);
    logic [Q_W-1:0]   u;
    logic [Q_W+7:0]   p;
    u = {~n[Q_W-1], n[Q_W-2:0]};
    p = {u, 8'b0} - {8'b0, u};
    return p[Q_W+7:Q_W];
  endfunction

  // floor(255 * n / 32768), negative gives zero
  function automatic logic [COLOR_W-1:0] z_byte(logic signed [Q_W-1:0] n);
    logic [Q_W+6:0] p;
    p = {n[Q_W-2:0], 8'b0} - {8'b0, n[Q_W-2:0]};
    return n[Q_W-1] ? '0 : p[Q_W+6:Q_W-1];
  endfunction

endpackage

>>> rtl/hmn_if.sv
// Stream channels of the height map to normal map block.
interface hmn_in_if;
  import hmn_pkg::*;
  logic                valid;
  logic                ready;
  logic [HEIGHT_W-1:0] height;

  modport source (output valid, output height, input ready);
  modport sink   (input valid, input height, output ready);
endinterface

interface hmn_out_if;
  import hmn_pkg::*;
  logic               valid;
  logic               ready;
  logic [PIX_W-1:0]   pix_x;
  logic [PIX_W-1:0]   pix_y;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               last_of_run;
  logic               image_done;

  modport source (output valid, output pix_x, output pix_y, output red, output green,
                  output blue, output last_of_run, output image_done, input ready);
  modport sink   (input valid, input pix_x, input pix_y, input red, input green,
                  input blue, input last_of_run, input image_done, output ready);
endinterface

>>> rtl/hmn_norm.sv
// Shared vector normalizer: sum of squares, bit-serial root, serial divides.
module hmn_norm import hmn_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  norm_req_t req_i,
  output norm_rsp_t rsp_o
);

  typedef enum logic [5:0] {
    N_IDLE  = 6'b000001,
    N_SQ    = 6'b000010,
    N_SQRT  = 6'b000100,
    N_DSET  = 6'b001000,
    N_DSTEP = 6'b010000,
    N_DONE  = 6'b100000
  } nstate_e;

  nstate_e state_q, state_d;

  logic [MAG_W-1:0]  mag_q [3];
  logic [MAG_W-1:0]  mag_d [3];
  logic [2:0]        sgn_q, sgn_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [SQ_W-1:0]   prod_q, prod_d;
  logic [ACC_W-1:0]  acc_q, acc_d;
  logic [RAD_W-1:0]  rad_q, rad_d;
  logic [REM_W-1:0]  rem_q, rem_d;
  logic [ROOT_W-1:0] root_q, root_d;
  logic [DREM_W-1:0] drem_q, drem_d;
  logic [DIV_STEPS-1:0] quo_q, quo_d;
  logic              ovf_q, ovf_d;
  logic [1:0]        idx_q, idx_d;
  nvec_t             res_q, res_d;

  logic [MAG_W-1:0]  sq_op;
  logic [MAG_W-1:0]  dv_mag;
  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic [DREM_W-1:0] dv;
  logic [DREM_W-1:0] d_sh;
  logic [DREM_W-1:0] root_x;
  logic [DIV_STEPS-1:0] q_fin;
  logic signed [Q_W-1:0] q_sgn;

  // Operand taps for the squarer and the divider
  always_comb begin
    unique case (cnt_q[1:0])
      2'd0:    sq_op = mag_q[0];
      2'd1:    sq_op = mag_q[1];
      2'd2:    sq_op = mag_q[2];
      default: sq_op = '0;
    endcase
    unique case (idx_q)
      2'd0:    dv_mag = mag_q[0];
      2'd1:    dv_mag = mag_q[1];
      2'd2:    dv_mag = mag_q[2];
      default: dv_mag = '0;
    endcase
  end

  assign rem_sh = {rem_q[REM_W-3:0], rad_q[RAD_W-1:RAD_W-2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign dv     = {2'b0, dv_mag, {DIV_SHIFT{1'b0}}};
  assign root_x = {1'b0, root_q};
  assign d_sh   = {drem_q[DREM_W-2:0], 1'b0};

  // Sequencer
  always_comb begin
    state_d = state_q;
    mag_d   = mag_q;
    sgn_d   = sgn_q;
    cnt_d   = cnt_q;
    prod_d  = prod_q;
    acc_d   = acc_q;
    rad_d   = rad_q;
    rem_d   = rem_q;
    root_d  = root_q;
    drem_d  = drem_q;
    quo_d   = quo_q;
    ovf_d   = ovf_q;
    idx_d   = idx_q;
    res_d   = res_q;
    q_fin   = '0;
    q_sgn   = '0;

    unique case (state_q)
      N_IDLE: begin
        if (req_i.start) begin
          sgn_d    = {req_i.z[VEC_W-1], req_i.y[VEC_W-1], req_i.x[VEC_W-1]};
          mag_d[0] = req_i.x[VEC_W-1] ? MAG_W'(-req_i.x) : MAG_W'(req_i.x);
          mag_d[1] = req_i.y[VEC_W-1] ? MAG_W'(-req_i.y) : MAG_W'(req_i.y);
          mag_d[2] = req_i.z[VEC_W-1] ? MAG_W'(-req_i.z) : MAG_W'(req_i.z);
          cnt_d    = '0;
          prod_d   = '0;
          acc_d    = '0;
          state_d  = N_SQ;
        end
      end

      // one square per cycle, registered and then accumulated
      N_SQ: begin
        prod_d = sq_op * sq_op;
        acc_d  = acc_q + ACC_W'(prod_q);
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(3)) begin
          rad_d   = {acc_q + ACC_W'(prod_q), {RAD_SHIFT{1'b0}}};
          rem_d   = '0;
          root_d  = '0;
          cnt_d   = '0;
          state_d = N_SQRT;
        end
      end

      // two radicand bits per step
      N_SQRT: begin
        rad_d = {rad_q[RAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d  = rem_sh - trial;
          root_d = {root_q[ROOT_W-2:0], 1'b1};
        end else begin
          rem_d  = rem_sh;
          root_d = {root_q[ROOT_W-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(SQRT_STEPS - 1)) begin
          idx_d = '0;
          if (root_d == '0) begin
            res_d   = BORDER_N;
            state_d = N_DONE;
          end else begin
            state_d = N_DSET;
          end
        end
      end

      // quotient overflows 15 bits when mag * 2^8 >= root
      N_DSET: begin
        drem_d  = dv;
        ovf_d   = dv >= root_x;
        quo_d   = '0;
        cnt_d   = '0;
        state_d = N_DSTEP;
      end

      N_DSTEP: begin
        if (d_sh >= root_x) begin
          drem_d = d_sh - root_x;
          quo_d  = {quo_q[DIV_STEPS-2:0], 1'b1};
        end else begin
          drem_d = d_sh;
          quo_d  = {quo_q[DIV_STEPS-2:0], 1'b0};
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          q_fin = ovf_q ? Q_ONE[DIV_STEPS-1:0] : quo_d;
          q_sgn = sgn_q[idx_q] ? -$signed({1'b0, q_fin}) : $signed({1'b0, q_fin});
          unique case (idx_q)
            2'd0:    res_d.x = q_sgn;
            2'd1:    res_d.y = q_sgn;
            default: res_d.z = q_sgn;
          endcase
          if (idx_q == 2'd2) begin
            state_d = N_DONE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = N_DSET;
          end
        end
      end

      N_DONE: begin
        state_d = N_IDLE;
      end

      default: state_d = N_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= N_IDLE;
      cnt_q   <= '0;
      idx_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      idx_q   <= idx_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    mag_q  <= mag_d;
    sgn_q  <= sgn_d;
    prod_q <= prod_d;
    acc_q  <= acc_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    drem_q <= drem_d;
    quo_q  <= quo_d;
    ovf_q  <= ovf_d;
    res_q  <= res_d;
  end

  assign rsp_o.done = (state_q == N_DONE);
  assign rsp_o.n    = res_q;

endmodule

>>> rtl/height_map_to_normal_map.sv
// Height map to normal map: raster heights in, normal map pixels out.
// Heights arrive one per transfer in raster order; a vertex normal grid one
// larger than the image is built from 2x2 height differences, and each output
// pixel is the normalized sum of its four corner vertices, given as bytes
// (red/green double as bump U/V). An input item causes zero to four pixels,
// the last one flagged last_of_run. Every normalization goes through one
// shared unit: squares are summed, a 29-step bit-serial root follows, then
// three serial divides (skipped for a zero root) and a done state. An
// interior item normalizes its vertex and then each pixel it emits, and is
// held longer by any output stall. A border item skips the vertex
// normalization. The input is not ready while an item is in work; a
// finished pixel waits in the output register while the next item is
// taken. The row stores need no clearing; configuration is taken at any
// time the block is idle.
`include "height_map_to_normal_map_macros.svh"

module height_map_to_normal_map import hmn_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i,
  hmn_in_if.sink               in_i,
  hmn_out_if.source            out_o
);

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int ROW_W  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int WCMP_W = ($clog2(MAX_WIDTH + 1) > CFG_W) ? $clog2(MAX_WIDTH + 1) : CFG_W;
  localparam int HCMP_W = ($clog2(MAX_HEIGHT + 1) > CFG_W) ? $clog2(MAX_HEIGHT + 1) : CFG_W;

  typedef enum logic [5:0] {
    T_IDLE  = 6'b000001,
    T_FETCH = 6'b000010,
    T_VNORM = 6'b000100,
    T_PSEL  = 6'b001000,
    T_PNORM = 6'b010000,
    T_PUT   = 6'b100000
  } tstate_e;

  tstate_e state_q, state_d;

  // Configuration
  logic [CFG_W-1:0] width_q, height_q;

  // Position and per-step state
  logic [COL_W-1:0]    col_q, col_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [HEIGHT_W-1:0] left_h_q, left_h_d;
  logic [HEIGHT_W-1:0] prev_h_q, prev_h_d;
  logic [HEIGHT_W-1:0] hv_q, hv_d;
  nvec_t               ul_q, ul_d;
  nvec_t               up_q, up_d;
  nvec_t               prev_v_q, prev_v_d;
  nvec_t               v_q, v_d;
  logic [3:0]          em_q, em_d;
  logic                end_q, end_d;
  logic [1:0]          e_q, e_d;

  // Output register
  logic               ovalid_q, ovalid_d;
  logic [PIX_W-1:0]   px_q, px_d, py_q, py_d;
  logic [COLOR_W-1:0] red_q, red_d, grn_q, grn_d, blu_q, blu_d;
  logic               lor_q, lor_d, done_q, done_d;

  // Row stores
  logic [HEIGHT_W-1:0] hrow_mem [MAX_WIDTH];
  nvec_t               vrow_mem [MAX_WIDTH];
  logic [HEIGHT_W-1:0] hrd_q;
  nvec_t               vrd_q;
  logic                h_we, v_we;
  nvec_t               v_wr;

  norm_req_t nreq;
  norm_rsp_t nrsp;

  logic                     in_xfer;
  logic [WCMP_W-1:0]        w_ext, w_cl, col_nx;
  logic [HCMP_W-1:0]        h_ext, h_cl, row_nx;
  logic                     at_end, at_last, r1, c1;
  logic signed [10:0]       s_v, t_v, as_v, at_v;
  logic signed [VEC_W-1:0]  vz_op;
  nvec_t                    pa, pb, pc, pd;
  logic signed [Q_W+1:0]    sx, sy, sz;
  logic [3:0]               later;
  logic [COL_W-1:0]         px_col;
  logic [ROW_W-1:0]         py_row;
  logic [PIX_W+COL_W-1:0]   px_ext;
  logic [PIX_W+ROW_W-1:0]   py_ext;
  logic                     fin;

  assign in_xfer = in_i.valid && in_i.ready;

  // Clamped image size and position flags
  always_comb begin
    w_ext = WCMP_W'(width_q);
    h_ext = HCMP_W'(height_q);
    if (w_ext == '0) begin
      w_cl = WCMP_W'(1);
    end else if (w_ext > WCMP_W'(MAX_WIDTH)) begin
      w_cl = WCMP_W'(MAX_WIDTH);
    end else begin
      w_cl = w_ext;
    end
    if (h_ext == '0) begin
      h_cl = HCMP_W'(1);
    end else if (h_ext > HCMP_W'(MAX_HEIGHT)) begin
      h_cl = HCMP_W'(MAX_HEIGHT);
    end else begin
      h_cl = h_ext;
    end
    col_nx  = WCMP_W'(col_q) + 1'b1;
    row_nx  = HCMP_W'(row_q) + 1'b1;
    at_end  = col_nx >= w_cl;
    at_last = row_nx >= h_cl;
    r1      = (row_q != '0);
    c1      = (col_q != '0);
  end

  // 2x2 differences: a upper left, b upper, c left, d current
  always_comb begin
    s_v   = $signed({3'b0, left_h_q}) - $signed({3'b0, hrd_q})
          + $signed({3'b0, prev_h_q}) - $signed({3'b0, hv_q});
    t_v   = $signed({3'b0, left_h_q}) - $signed({3'b0, prev_h_q})
          + $signed({3'b0, hrd_q}) - $signed({3'b0, hv_q});
    as_v  = s_v[10] ? -s_v : s_v;
    at_v  = t_v[10] ? -t_v : t_v;
    vz_op = VEC_W'(Z_BASE) - $signed({{(VEC_W-13){1'b0}}, as_v, 2'b00})
          - $signed({{(VEC_W-11){1'b0}}, at_v});
  end

  // Corner vertices of the pixel in turn
  always_comb begin
    unique case (e_q)
      2'd0: begin pa = ul_q;     pb = up_q;     pc = prev_v_q; pd = v_q;      end
      2'd1: begin pa = up_q;     pb = BORDER_N; pc = v_q;      pd = BORDER_N; end
      2'd2: begin pa = prev_v_q; pb = v_q;      pc = BORDER_N; pd = BORDER_N; end
      default: begin pa = v_q;   pb = BORDER_N; pc = BORDER_N; pd = BORDER_N; end
    endcase
    sx = (Q_W+2)'(pa.x) + (Q_W+2)'(pb.x) + (Q_W+2)'(pc.x) + (Q_W+2)'(pd.x);
    sy = (Q_W+2)'(pa.y) + (Q_W+2)'(pb.y) + (Q_W+2)'(pc.y) + (Q_W+2)'(pd.y);
    sz = (Q_W+2)'(pa.z) + (Q_W+2)'(pb.z) + (Q_W+2)'(pc.z) + (Q_W+2)'(pd.z);
  end

  // Output position of the pixel in turn
  always_comb begin
    px_col = (e_q == 2'd0 || e_q == 2'd2) ? col_q - 1'b1 : col_q;
    py_row = (e_q == 2'd0 || e_q == 2'd1) ? row_q - 1'b1 : row_q;
    px_ext = {{PIX_W{1'b0}}, px_col};
    py_ext = {{PIX_W{1'b0}}, py_row};
    later  = em_q >> ({1'b0, e_q} + 3'd1);
  end

  // Sequencer
  always_comb begin
    state_d  = state_q;
    col_d    = col_q;
    row_d    = row_q;
    left_h_d = left_h_q;
    prev_h_d = prev_h_q;
    hv_d     = hv_q;
    ul_d     = ul_q;
    up_d     = up_q;
    prev_v_d = prev_v_q;
    v_d      = v_q;
    em_d     = em_q;
    end_d    = end_q;
    e_d      = e_q;
    ovalid_d = ovalid_q && !out_o.ready;
    px_d     = px_q;
    py_d     = py_q;
    red_d    = red_q;
    grn_d    = grn_q;
    blu_d    = blu_q;
    lor_d    = lor_q;
    done_d   = done_q;
    h_we     = 1'b0;
    v_we     = 1'b0;
    v_wr     = BORDER_N;
    fin      = 1'b0;
    nreq     = '0;

    unique case (state_q)
      T_IDLE: begin
        if (in_xfer) begin
          hv_d    = in_i.height;
          state_d = T_FETCH;
        end
      end

      // store reads are ready; start the vertex
      T_FETCH: begin
        left_h_d = hrd_q;
        prev_h_d = hv_q;
        up_d     = vrd_q;
        h_we     = 1'b1;
        end_d    = at_end;
        em_d     = {at_last & at_end, at_last & c1, r1 & at_end, r1 & c1};
        e_d      = '0;
        if (r1 && c1) begin
          nreq.start = 1'b1;
          nreq.x     = {{(VEC_W-13){s_v[10]}}, s_v, 2'b00};
          nreq.y     = {{(VEC_W-13){t_v[10]}}, t_v, 2'b00};
          nreq.z     = vz_op;
          state_d    = T_VNORM;
        end else begin
          v_d     = BORDER_N;
          v_we    = 1'b1;
          state_d = T_PSEL;
        end
      end

      T_VNORM: begin
        if (nrsp.done) begin
          v_d     = nrsp.n;
          v_wr    = nrsp.n;
          v_we    = 1'b1;
          state_d = T_PSEL;
        end
      end

      // next pixel of this step, if any
      T_PSEL: begin
        if (em_q[e_q]) begin
          nreq.start = 1'b1;
          nreq.x     = {{(VEC_W-Q_W-4){sx[Q_W+1]}}, sx, 2'b00};
          nreq.y     = {{(VEC_W-Q_W-4){sy[Q_W+1]}}, sy, 2'b00};
          nreq.z     = VEC_W'(sz);
          state_d    = T_PNORM;
        end else if (e_q == 2'd3) begin
          fin = 1'b1;
        end else begin
          e_d = e_q + 1'b1;
        end
      end

      T_PNORM: begin
        if (nrsp.done) begin
          state_d = T_PUT;
        end
      end

      // wait for the output register
      T_PUT: begin
        if (!ovalid_q || out_o.ready) begin
          ovalid_d = 1'b1;
          px_d     = px_ext[PIX_W-1:0];
          py_d     = py_ext[PIX_W-1:0];
          red_d    = ofs_byte(nrsp.n.x);
          grn_d    = ofs_byte(nrsp.n.y);
          blu_d    = z_byte(nrsp.n.z);
          lor_d    = ~|later;
          done_d   = (e_q == 2'd3);
          if (e_q == 2'd3) begin
            fin = 1'b1;
          end else begin
            e_d     = e_q + 1'b1;
            state_d = T_PSEL;
          end
        end
      end

      default: state_d = T_IDLE;
    endcase

    // end of step: advance raster position
    if (fin) begin
      ul_d     = up_q;
      prev_v_d = v_q;
      state_d  = T_IDLE;
      if (end_q) begin
        col_d = '0;
        row_d = at_last ? '0 : row_q + 1'b1;
      end else begin
        col_d = col_q + 1'b1;
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= T_IDLE;
      width_q  <= CFG_W'(1);
      height_q <= CFG_W'(1);
      col_q    <= '0;
      row_q    <= '0;
      left_h_q <= '0;
      ul_q     <= BORDER_N;
      e_q      <= '0;
      em_q     <= '0;
      end_q    <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      col_q    <= col_d;
      row_q    <= row_d;
      left_h_q <= left_h_d;
      ul_q     <= ul_d;
      e_q      <= e_d;
      em_q     <= em_d;
      end_q    <= end_d;
      ovalid_q <= ovalid_d;
      if (cfg_we_i) begin
        if (cfg_idx_i == CFG_IDX_WIDTH) begin
          width_q <= cfg_data_i;
        end else begin
          height_q <= cfg_data_i;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    prev_h_q <= prev_h_d;
    hv_q     <= hv_d;
    up_q     <= up_d;
    prev_v_q <= prev_v_d;
    v_q      <= v_d;
    px_q     <= px_d;
    py_q     <= py_d;
    red_q    <= red_d;
    grn_q    <= grn_d;
    blu_q    <= blu_d;
    lor_q    <= lor_d;
    done_q   <= done_d;
  end

  // Row stores, read at the current column every cycle
  always_ff @(posedge clk_i) begin
    if (h_we) begin
      hrow_mem[col_q] <= hv_q;
    end
    hrd_q <= hrow_mem[col_q];
  end

  always_ff @(posedge clk_i) begin
    if (v_we) begin
      vrow_mem[col_q] <= v_wr;
    end
    vrd_q <= vrow_mem[col_q];
  end

  hmn_norm u_norm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (nreq),
    .rsp_o  (nrsp)
  );

  assign in_i.ready        = (state_q == T_IDLE);
  assign out_o.valid       = ovalid_q;
  assign out_o.pix_x       = px_q;
  assign out_o.pix_y       = py_q;
  assign out_o.red         = red_q;
  assign out_o.green       = grn_q;
  assign out_o.blue        = blu_q;
  assign out_o.last_of_run = lor_q;
  assign out_o.image_done  = done_q;

  `HMN_ASSERT_NEXT(a_xfer_fetch, in_xfer, state_q == T_FETCH, "transfer did not start a step")
  `HMN_ASSERT_SAME(a_norm_owner, nrsp.done, state_q == T_VNORM || state_q == T_PNORM,
                   "normalizer finished with nobody waiting")
  `HMN_ASSERT_SAME(a_done_last, out_o.valid && out_o.image_done, out_o.last_of_run,
                   "image end pixel not last of its run")

endmodule

>>> test/height_map_to_normal_map_tb.sv
// Testbench of the height map to normal map block: directed and random images.
`timescale 1ns / 100ps

module height_map_to_normal_map_tb;
  import hmn_pkg::*;

  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int SETTLE      = 600;   // above the worst item latency

  // Height patterns of an image
  typedef enum int {PAT_RANDOM, PAT_CHECKER, PAT_RAMP, PAT_FLAT_MAX} pattern_e;

  typedef struct {
    logic [PIX_W-1:0]   pix_x;
    logic [PIX_W-1:0]   pix_y;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
    logic               last_of_run;
    logic               image_done;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [CFG_W-1:0] cfg_data_i;

  hmn_in_if  height_ch ();
  hmn_out_if pixel_ch ();

  height_map_to_normal_map u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (height_ch.sink),
    .out_o      (pixel_ch.source)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Predictor state
  int unsigned cur_width = 1, cur_height = 1;
  logic [HEIGHT_W-1:0] above_heights [DEF_MAX_WIDTH];
  nvec_t above_vertices [DEF_MAX_WIDTH];
  logic [HEIGHT_W-1:0] prev_above_height = '0;
  nvec_t prev_above_vertex = BORDER_N;
  int unsigned col_pos = 0, row_pos = 0;

  pixel_t expected_pixels [$];
  int mismatches = 0;
  int pixels_seen = 0;
  int heights_sent = 0;
  bit calm = 1'b0;
  longint cycles = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, b;
    res = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic logic signed [Q_W-1:0] unit_comp(longint v, longint unsigned r);
    longint unsigned m, q;
    m = (v < 0) ? -v : v;
    q = (m << 23) / r;
    if (q > 32767) q = 32767;
    return (v < 0) ? -$signed(q[Q_W-1:0]) : $signed(q[Q_W-1:0]);
  endfunction

  function automatic nvec_t unit_vec(longint x, longint y, longint z);
    longint unsigned ax, ay, az, r;
    nvec_t n;
    ax = (x < 0) ? -x : x;
    ay = (y < 0) ? -y : y;
    az = (z < 0) ? -z : z;
    r = root_floor((ax * ax + ay * ay + az * az) << 16);
    if (r == 0) return BORDER_N;
    n.x = unit_comp(x, r);
    n.y = unit_comp(y, r);
    n.z = unit_comp(z, r);
    return n;
  endfunction

  function automatic logic [COLOR_W-1:0] clamp_byte(longint v);
    if (v < 0) return '0;
    if (v > 255) return 8'd255;
    return v[COLOR_W-1:0];
  endfunction

  // Pixel color from the four corner vertices
  function automatic pixel_t shade_pixel(int unsigned px, int unsigned py,
                                         nvec_t a, nvec_t b, nvec_t c, nvec_t d,
                                         bit done);
    longint sx, sy, sz;
    nvec_t n;
    pixel_t p;
    sx = longint'(a.x) + b.x + c.x + d.x;
    sy = longint'(a.y) + b.y + c.y + d.y;
    sz = longint'(a.z) + b.z + c.z + d.z;
    n = unit_vec(4 * sx, 4 * sy, sz);
    p.pix_x = px[PIX_W-1:0];
    p.pix_y = py[PIX_W-1:0];
    p.red = clamp_byte((255 * (32768 + longint'(n.x))) >>> 16);
    p.green = clamp_byte((255 * (32768 + longint'(n.y))) >>> 16);
    p.blue = clamp_byte((255 * longint'(n.z)) >>> 15);
    p.last_of_run = 1'b0;
    p.image_done = done;
    return p;
  endfunction

  // Advance the normal map predictor by one height sample
  task automatic predict_pixels(logic [HEIGHT_W-1:0] hv);
    int unsigned w, h, c, r, k;
    bit row_end, last_row;
    nvec_t v, up, lv, ul;
    int s, t, as, at, a, b, cc, d;
    pixel_t got [4];
    w = (cur_width < 1) ? 1 : (cur_width > DEF_MAX_WIDTH ? DEF_MAX_WIDTH : cur_width);
    h = (cur_height < 1) ? 1 : (cur_height > DEF_MAX_HEIGHT ? DEF_MAX_HEIGHT : cur_height);
    c = (col_pos >= DEF_MAX_WIDTH) ? DEF_MAX_WIDTH - 1 : col_pos;
    r = row_pos;
    k = 0;
    row_end = (c + 1 >= w);
    last_row = (r + 1 >= h);
    up = above_vertices[c];
    ul = prev_above_vertex;
    lv = (c >= 1) ? above_vertices[c-1] : BORDER_N;
    if (r == 0 || c == 0) begin
      v = BORDER_N;
    end else begin
      a = prev_above_height;
      b = above_heights[c];
      cc = above_heights[c-1];
      d = hv;
      s = a - b + cc - d;
      t = a - cc + b - d;
      as = (s < 0) ? -s : s;
      at = (t < 0) ? -t : t;
      v = unit_vec(4 * longint'(s), 4 * longint'(t), 2550 - 4 * longint'(as) - at);
    end
    prev_above_height = above_heights[c];
    above_heights[c] = hv;
    prev_above_vertex = up;
    above_vertices[c] = v;
    if (r >= 1 && c >= 1) got[k++] = shade_pixel(c - 1, r - 1, ul, up, lv, v, 1'b0);
    if (r >= 1 && row_end) got[k++] = shade_pixel(c, r - 1, up, BORDER_N, v, BORDER_N, 1'b0);
    if (last_row && c >= 1) got[k++] = shade_pixel(c - 1, r, lv, v, BORDER_N, BORDER_N, 1'b0);
    if (last_row && row_end) got[k++] = shade_pixel(c, r, v, BORDER_N, BORDER_N, BORDER_N, 1'b1);
    if (k > 0) got[k-1].last_of_run = 1'b1;
    for (int i = 0; i < k; i++) expected_pixels.push_back(got[i]);
    if (row_end) begin
      col_pos = 0;
      row_pos = last_row ? 0 : r + 1;
    end else begin
      col_pos = c + 1;
    end
  endtask

  // One height transfer, then an optional random gap
  task automatic send_height(logic [HEIGHT_W-1:0] hv);
    height_ch.valid <= 1'b1;
    height_ch.height <= hv;
    // ready only moves at a rising edge, so look at it between edges
    @(negedge clk_i);
    while (!height_ch.ready) @(negedge clk_i);
    @(posedge clk_i);
    predict_pixels(hv);
    heights_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      height_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk_i);
    end
  endtask

  task automatic drain_and_settle();
    height_ch.valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int unsigned value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value[CFG_W-1:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_IDX_WIDTH) cur_width = value;
    else cur_height = value;
  endtask

  function automatic logic [HEIGHT_W-1:0] pick_height(pattern_e pat, int x, int y);
    case (pat)
      PAT_CHECKER:  return ((x + y) % 2) ? 8'd255 : 8'd0;
      PAT_RAMP:     return 8'((x * 63 + y * 97) & 8'hff);
      PAT_FLAT_MAX: return 8'd255;
      default: begin
        case ($urandom_range(0, 5))
          0:       return 8'd0;
          1:       return 8'd255;
          default: return 8'($urandom_range(0, 255));
        endcase
      end
    endcase
  endfunction

  // Whole image at a given size; the block must be idle on entry
  task automatic run_image(int w, int h, pattern_e pat, bit hold_mid);
    drain_and_settle();
    write_reg(CFG_IDX_WIDTH, w);
    write_reg(CFG_IDX_HEIGHT, h);
    for (int y = 0; y < h; y++) begin
      for (int x = 0; x < w; x++) begin
        if (hold_mid && y == h / 2 && x == w / 2) begin
          // let every pending pixel come out before going on
          height_ch.valid <= 1'b0;
          while (expected_pixels.size() != 0) @(posedge clk_i);
        end
        send_height(pick_height(pat, x, y));
      end
    end
  endtask

  task automatic test_single_pixel();
    run_image(1, 1, PAT_FLAT_MAX, 1'b0);
  endtask

  task automatic test_extreme_slopes();
    run_image(3, 3, PAT_CHECKER, 1'b0);
    run_image(5, 2, PAT_RAMP, 1'b0);
  endtask

  task automatic test_long_row();
    run_image(160, 1, PAT_RANDOM, 1'b0);
  endtask

  task automatic test_tall_column();
    run_image(1, 100, PAT_RANDOM, 1'b0);
  endtask

  task automatic test_random_images();
    int w, h;
    bit held;
    held = 1'b0;
    while (heights_sent < 410) begin
      if (heights_sent > 340) calm = 1'b1;
      w = $urandom_range(1, 12);
      h = $urandom_range(1, 8);
      run_image(w, h, PAT_RANDOM, !held && w * h >= 6);
      if (w * h >= 6) held = 1'b1;
    end
  endtask

  // Output ready with random stall bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (calm) begin
      pixel_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      pixel_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 19) - 1;
      pixel_ch.ready <= 1'b0;
    end else begin
      pixel_ch.ready <= 1'b1;
    end
  end

  // Compare each pixel transfer with the oldest prediction; the handshake
  // is looked at between edges, the transfer is the next rising edge
  always @(negedge clk_i) begin
    pixel_t want;
    if (rst_ni && pixel_ch.valid && pixel_ch.ready) begin
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel at (%0d,%0d)", pixel_ch.pix_x, pixel_ch.pix_y);
        mismatches++;
      end else begin
        want = expected_pixels.pop_front();
        if (pixel_ch.pix_x !== want.pix_x) begin
          $error("pix_x expected %0d got %0d", want.pix_x, pixel_ch.pix_x);
          mismatches++;
        end
        if (pixel_ch.pix_y !== want.pix_y) begin
          $error("pix_y expected %0d got %0d", want.pix_y, pixel_ch.pix_y);
          mismatches++;
        end
        if (pixel_ch.red !== want.red) begin
          $error("red expected %0d got %0d", want.red, pixel_ch.red);
          mismatches++;
        end
        if (pixel_ch.green !== want.green) begin
          $error("green expected %0d got %0d", want.green, pixel_ch.green);
          mismatches++;
        end
        if (pixel_ch.blue !== want.blue) begin
          $error("blue expected %0d got %0d", want.blue, pixel_ch.blue);
          mismatches++;
        end
        if (pixel_ch.last_of_run !== want.last_of_run) begin
          $error("last_of_run expected %0b got %0b", want.last_of_run, pixel_ch.last_of_run);
          mismatches++;
        end
        if (pixel_ch.image_done !== want.image_done) begin
          $error("image_done expected %0b got %0b", want.image_done, pixel_ch.image_done);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("end of test: mismatches");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_IDX_WIDTH;
    cfg_data_i = '0;
    height_ch.valid = 1'b0;
    height_ch.height = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_single_pixel();
    test_extreme_slopes();
    test_long_row();
    test_tall_column();
    test_random_images();
    drain_and_settle();

    $display("sent %0d heights over directed, long-row, tall-column and random images",
             heights_sent);
    $display("checked %0d normal map pixels with %0d mismatches", pixels_seen, mismatches);
    if (mismatches == 0 && expected_pixels.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
